FILE: rtl/apf_pkg.sv
// ----------------------------------------------------------------------------
// apf_pkg
// Shared types, widths and codes for the first-order allpass filter bank.
// ----------------------------------------------------------------------------
package apf_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEFF_W    = 16;
  localparam int GAIN_W     = 20;
  localparam int STATE_W    = 24;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // Serial multiplier: multiplicand up to the 27-bit shelf term, multiplier
  // up to the 20-bit shelf gain.
  localparam int MA_W   = 27;
  localparam int MB_W   = 20;
  localparam int PROD_W = MA_W + MB_W;
  localparam int CNT_W  = $clog2(MB_W);

  // Rounded product and saturation working widths
  localparam int RND_W = 34;
  localparam int SAT_W = 35;
  localparam int T_W   = 27;

  // Filter modes
  localparam logic [MODE_W-1:0] MODE_LOWPASS   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HIGHPASS  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOWSHELF  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_HIGHSHELF = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd2;

  localparam logic signed [SAT_W-1:0] STATE_MAX  = SAT_W'((1 <<< (STATE_W - 1)) - 1);
  localparam logic signed [SAT_W-1:0] STATE_MIN  = -SAT_W'(1 <<< (STATE_W - 1));
  localparam logic signed [SAT_W-1:0] SAMPLE_MAX = SAT_W'((1 <<< (SAMPLE_W - 1)) - 1);
  localparam logic signed [SAT_W-1:0] SAMPLE_MIN = -SAT_W'(1 <<< (SAMPLE_W - 1));

  typedef struct packed {
    logic                       channel;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       block_last_in;
  } in_item_t;

  typedef struct packed {
    logic                       channel_out;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       block_last_out;
  } out_item_t;

  typedef struct packed {
    logic                     start;
    logic signed [MA_W-1:0]   mcand;
    logic signed [MB_W-1:0]   mplier;
  } mul_req_t;

  function automatic logic signed [STATE_W-1:0] sat_state(logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] r;
    r = v;
    if (v > STATE_MAX) r = STATE_MAX;
    if (v < STATE_MIN) r = STATE_MIN;
    return r[STATE_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] r;
    r = v;
    if (v > SAMPLE_MAX) r = SAMPLE_MAX;
    if (v < SAMPLE_MIN) r = SAMPLE_MIN;
    return r[SAMPLE_W-1:0];
  endfunction

endpackage

FILE: rtl/apf_serial_mult.sv
// ----------------------------------------------------------------------------
// apf_serial_mult
// Signed serial-parallel multiplier: one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module apf_serial_mult (
  input  logic                                   clk,
  input  logic                                   rst,
  input  apf_pkg::mul_req_t                      req,
  output logic                                   done,
  output logic signed [apf_pkg::PROD_W-1:0]      product
);

  logic signed [apf_pkg::MA_W-1:0] mcand;
  logic signed [apf_pkg::MA_W:0]   hi;
  logic        [apf_pkg::MB_W-1:0] lo;
  logic        [apf_pkg::CNT_W-1:0] cnt;
  logic                            busy;
  logic                            last_bit;
  logic signed [apf_pkg::MA_W:0]   addend;
  logic signed [apf_pkg::MA_W:0]   sum;

  // The top multiplier bit carries negative weight: subtract on that step
  assign last_bit = (cnt == apf_pkg::CNT_W'(apf_pkg::MB_W - 1));

  always_comb begin
    addend = '0;
    if (lo[0]) begin
      if (last_bit) begin
        addend = -((apf_pkg::MA_W + 1)'(mcand));
      end else begin
        addend = (apf_pkg::MA_W + 1)'(mcand);
      end
    end
    sum = hi + addend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (last_bit) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mcand <= req.mcand;
      hi    <= '0;
      lo    <= req.mplier;
    end else if (busy) begin
      hi <= {sum[apf_pkg::MA_W], sum[apf_pkg::MA_W:1]};
      lo <= {sum[0], lo[apf_pkg::MB_W-1:1]};
    end
  end

  assign product = {hi[apf_pkg::MA_W-1:0], lo};

endmodule

FILE: rtl/apf_state_mem.sv
// ----------------------------------------------------------------------------
// apf_state_mem
// Per-channel allpass state, cleared to zero at reset.
// ----------------------------------------------------------------------------
module apf_state_mem #(
  parameter int CHANNELS = 2,
  parameter int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [IDX_W-1:0]                    rd_addr,
  output logic signed [apf_pkg::STATE_W-1:0]  rd_data,
  input  logic                                wr_en,
  input  logic [IDX_W-1:0]                    wr_addr,
  input  logic signed [apf_pkg::STATE_W-1:0]  wr_data
);

  logic signed [apf_pkg::STATE_W-1:0] mem [CHANNELS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        mem[i] <= '0;
      end
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign rd_data = mem[rd_addr];

endmodule

FILE: rtl/first_order_allpass_filter_bank.sv
// ----------------------------------------------------------------------------
// first_order_allpass_filter_bank
// Per-channel first-order allpass with lowpass, highpass and shelf outputs.
// ----------------------------------------------------------------------------
// One item in, one item out. Each item runs through a single shared serial
// multiplier that retires one multiplier bit per cycle: c*s for the new
// state, c*h for the allpass output and, in the shelf modes only, H0*t for
// the shelf term. A new item is accepted only after the item in flight has
// finished its multiplier passes and been loaded into the output register,
// and that load waits until the previous result has left the register. A
// finished item sits in the output register, so the next item is accepted
// while it waits to be taken. The channel state is a small register file
// cleared at reset; an item on a channel number at or beyond CHANNELS is
// filtered against a zero state and leaves the store untouched.
// Configuration is taken at any time (ready is always high) but is meant to
// be written only while the block is idle.
// ----------------------------------------------------------------------------
module first_order_allpass_filter_bank #(
  parameter int CHANNELS = 2
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input items
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  apf_pkg::in_item_t                    in_data,
  // result items
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output apf_pkg::out_item_t                   out_data,
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [apf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [apf_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Sequencer codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_P_MUL = 4'd1;
  localparam logic [3:0] S_H     = 4'd2;
  localparam logic [3:0] S_A_MUL = 4'd3;
  localparam logic [3:0] S_T     = 4'd4;
  localparam logic [3:0] S_Y     = 4'd5;
  localparam logic [3:0] S_G_MUL = 4'd6;
  localparam logic [3:0] S_SHELF = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  localparam logic signed [apf_pkg::PROD_W-1:0] RND15 = apf_pkg::PROD_W'(1 <<< 14);
  localparam logic signed [apf_pkg::PROD_W-1:0] RND13 = apf_pkg::PROD_W'(1 <<< 12);

  logic [3:0] state;
  logic [3:0] state_next;

  // configuration registers
  logic [apf_pkg::MODE_W-1:0]          mode;
  logic signed [apf_pkg::COEFF_W-1:0]  coeff;
  logic signed [apf_pkg::GAIN_W-1:0]   gain;

  // item in flight
  logic                                 ch;
  logic                                 ch_ok;
  logic                                 last;
  logic signed [apf_pkg::SAMPLE_W-1:0]  x;
  logic signed [apf_pkg::STATE_W-1:0]   s;
  logic signed [apf_pkg::T_W-1:0]       t;
  logic signed [apf_pkg::RND_W-1:0]     rnd;
  logic signed [apf_pkg::SAMPLE_W-1:0]  y;

  logic                                 in_accept;
  logic                                 in_ch_ok;
  logic signed [apf_pkg::STATE_W-1:0]   mem_rd;
  logic signed [apf_pkg::STATE_W-1:0]   s_in;
  logic signed [apf_pkg::STATE_W-1:0]   h_calc;
  logic signed [apf_pkg::T_W-1:0]       t_calc;
  logic signed [apf_pkg::SAMPLE_W-1:0]  y_pass;
  logic signed [apf_pkg::SAMPLE_W-1:0]  y_shelf;
  logic                                 mode_sum;
  logic                                 mode_shelf;
  logic                                 load_out;
  logic                                 mem_we;

  apf_pkg::mul_req_t                    mul_req;
  logic                                 mul_done;
  logic signed [apf_pkg::PROD_W-1:0]    product;
  logic signed [apf_pkg::PROD_W-1:0]    prod_r15;
  logic signed [apf_pkg::PROD_W-1:0]    prod_r13;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  // Channel 0 always exists; channel 1 only when the bank has two or more
  assign in_ch_ok = (CHANNELS > 1) || (in_data.channel == 1'b0);
  assign s_in     = in_ch_ok ? mem_rd : '0;

  // Lowpass and low shelf add the allpass output, the others subtract it
  assign mode_sum   = (mode == apf_pkg::MODE_LOWPASS) || (mode == apf_pkg::MODE_LOWSHELF);
  assign mode_shelf = (mode == apf_pkg::MODE_LOWSHELF) || (mode == apf_pkg::MODE_HIGHSHELF);

  apf_state_mem #(
    .CHANNELS (CHANNELS),
    .IDX_W    (IDX_W)
  ) u_state (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (IDX_W'(in_data.channel)),
    .rd_data (mem_rd),
    .wr_en   (mem_we),
    .wr_addr (IDX_W'(ch)),
    .wr_data (h_calc)
  );

  apf_serial_mult u_mult (
    .clk     (clk),
    .rst     (rst),
    .req     (mul_req),
    .done    (mul_done),
    .product (product)
  );

  // Round half up and drop the extra fraction bits of the product
  assign prod_r15 = (product + RND15) >>> 15;
  assign prod_r13 = (product + RND13) >>> 13;

  // h = x - round(c*s), saturated to the state range
  assign h_calc = apf_pkg::sat_state(apf_pkg::SAT_W'(x) - apf_pkg::SAT_W'(rnd));

  // t = x +/- (s + round(c*h))
  always_comb begin
    if (mode_sum) begin
      t_calc = apf_pkg::T_W'(x) + apf_pkg::T_W'(s) + apf_pkg::T_W'(rnd);
    end else begin
      t_calc = apf_pkg::T_W'(x) - apf_pkg::T_W'(s) - apf_pkg::T_W'(rnd);
    end
  end

  assign y_pass  = apf_pkg::sat_sample((apf_pkg::SAT_W'(t) + apf_pkg::SAT_W'(1)) >>> 1);
  assign y_shelf = apf_pkg::sat_sample(apf_pkg::SAT_W'(x) + apf_pkg::SAT_W'(rnd));

  // Sequencer: next state, multiplier requests, store write and output load
  always_comb begin
    state_next     = state;
    mul_req.start  = 1'b0;
    mul_req.mcand  = apf_pkg::MA_W'(s_in);
    mul_req.mplier = apf_pkg::MB_W'(coeff);
    mem_we         = 1'b0;
    load_out       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          mul_req.start = 1'b1;
          state_next    = S_P_MUL;
        end
      end
      S_P_MUL: begin
        if (mul_done) state_next = S_H;
      end
      S_H: begin
        mul_req.start = 1'b1;
        mul_req.mcand = apf_pkg::MA_W'(h_calc);
        mem_we        = ch_ok;
        state_next    = S_A_MUL;
      end
      S_A_MUL: begin
        if (mul_done) state_next = S_T;
      end
      S_T: begin
        state_next = S_Y;
      end
      S_Y: begin
        if (mode_shelf) begin
          mul_req.start  = 1'b1;
          mul_req.mcand  = t;
          mul_req.mplier = gain;
          state_next     = S_G_MUL;
        end else begin
          state_next = S_OUT;
        end
      end
      S_G_MUL: begin
        if (mul_done) state_next = S_SHELF;
      end
      S_SHELF: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      mode      <= apf_pkg::MODE_LOWPASS;
      coeff     <= '0;
      gain      <= '0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (load_out) out_valid <= 1'b1;
      if (cfg_valid) begin
        unique case (cfg_index)
          apf_pkg::REG_MODE:  mode  <= cfg_data[apf_pkg::MODE_W-1:0];
          apf_pkg::REG_COEFF: coeff <= cfg_data[apf_pkg::COEFF_W-1:0];
          apf_pkg::REG_GAIN:  gain  <= cfg_data[apf_pkg::GAIN_W-1:0];
          default: ;  // drop writes beyond the register list
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      ch    <= in_data.channel;
      ch_ok <= in_ch_ok;
      last  <= in_data.block_last_in;
      x     <= in_data.sample_in;
      s     <= s_in;
    end
    if (mul_done) begin
      if (state == S_G_MUL) begin
        rnd <= prod_r13[apf_pkg::RND_W-1:0];
      end else begin
        rnd <= prod_r15[apf_pkg::RND_W-1:0];
      end
    end
    if (state == S_T) t <= t_calc;
    if (state == S_Y) y <= y_pass;
    if (state == S_SHELF) y <= y_shelf;
    if (load_out) begin
      out_data.channel_out    <= ch;
      out_data.sample_out     <= y;
      out_data.block_last_out <= last;
    end
  end

endmodule
